/* design/gmst_pkg.sv */
// Package for the global multiprocessor scheduler tick block.
// Holds opcodes, policy codes, register indexes and field widths; no dependencies.
package gmst_pkg;

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth = 4;

   localparam logic [CsrIndexWidth-1:0] CSR_PROCESSORS = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_POLICY = 1'd1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] POLICY_EDF = 2'd0;
   localparam logic [1:0] POLICY_FIXED = 2'd1;
   localparam logic [1:0] POLICY_LLF = 2'd2;

   localparam int unsigned FieldWidth = 8;
   localparam int unsigned IndexWidth = 3;
   localparam int unsigned MaskWidth = 8;
   localparam int unsigned ProcWidth = 4;

   // Control broadcast from the sequencer to every task cell
   typedef struct packed {
      logic       load;
      logic       release_en;
      logic       rank_clear;
      logic       rank_step;
      logic       update;
      logic [1:0] policy;
   } cell_ctrl_type;

endpackage

/* design/gmst_cell.sv */
// One task cell of the scheduler chain: parameters, job state and rank counter.
// Depends on gmst_pkg. A circulating ring of keys passes through all cells.
module gmst_cell #(
   parameter int TIME_WIDTH = 8,
   parameter int TASKS = 8,
   parameter int MY_INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gmst_pkg::cell_ctrl_type          ctrl,
   input  logic                             load_sel,
   input  logic                             release_bit,
   input  logic [TIME_WIDTH-1:0]            wcet_value,
   input  logic [TIME_WIDTH-1:0]            period_value,
   input  logic [TIME_WIDTH-1:0]            deadline_value,
   input  logic [$clog2(TASKS+1)-1:0]       proc_limit,
   // ring data from the previous cell
   input  logic                             ring_act_in,
   input  logic signed [TIME_WIDTH+1:0]     ring_key_in,
   input  logic [$clog2(TASKS+1)-1:0]       ring_idx_in,
   output logic                             ring_act_out,
   output logic signed [TIME_WIDTH+1:0]     ring_key_out,
   output logic [$clog2(TASKS+1)-1:0]       ring_idx_out,
   output logic                             active,
   output logic                             run,
   output logic                             missed
);

   localparam int RW = $clog2(TASKS+1);
   localparam int KW = TIME_WIDTH + 2;

   logic [TIME_WIDTH-1:0] wcet_ff, period_ff, deadline_ff, work_ff, tnp_ff;
   logic [TIME_WIDTH-1:0] work_in, tnp_in;
   logic [RW-1:0]         ahead_ff, ahead_in;
   logic                  run_ff, run_in, miss_ff, miss_in;
   logic                  ract_ff, ract_in;
   logic signed [KW-1:0]  rkey_ff, rkey_in;
   logic [RW-1:0]         ridx_ff, ridx_in;

   logic signed [KW-1:0]  ttd, my_key, ttd_next;
   logic [TIME_WIDTH-1:0] tnp_dec, work_dec;
   logic                  my_act, other_ahead, do_run;

   // Time to deadline, clamped at zero
   function automatic logic signed [KW-1:0] calc_ttd(
      input logic [TIME_WIDTH-1:0] tnp, input logic [TIME_WIDTH-1:0] per,
      input logic [TIME_WIDTH-1:0] dl);
      logic signed [KW-1:0] v;
      v = $signed({2'b00, tnp}) - ($signed({2'b00, per}) - $signed({2'b00, dl}));
      return (v > 0) ? v : '0;
   endfunction

   always_comb begin
      my_act = (work_ff != '0);
      ttd = calc_ttd(tnp_ff, period_ff, deadline_ff);
      if (ctrl.policy == gmst_pkg::POLICY_LLF) begin
         my_key = ttd - $signed({2'b00, work_ff});
      end else begin
         my_key = ttd;
      end
      // Compare the ring entry against this task
      if (ring_idx_in == RW'(MY_INDEX)) begin
         other_ahead = 1'b0;
      end else if (!ring_act_in && !my_act) begin
         other_ahead = (ring_idx_in < RW'(MY_INDEX));
      end else if (ring_act_in != my_act) begin
         other_ahead = ring_act_in;
      end else if (ctrl.policy == gmst_pkg::POLICY_FIXED) begin
         other_ahead = (ring_idx_in < RW'(MY_INDEX));
      end else if (ring_key_in == my_key) begin
         other_ahead = (ring_idx_in < RW'(MY_INDEX));
      end else begin
         other_ahead = (ring_key_in < my_key);
      end
   end

   always_comb begin
      work_in = work_ff;
      tnp_in = tnp_ff;
      ahead_in = ahead_ff;
      run_in = run_ff;
      miss_in = miss_ff;
      ract_in = ring_act_in;
      rkey_in = ring_key_in;
      ridx_in = ring_idx_in;
      do_run = my_act && (ahead_ff < proc_limit);
      work_dec = do_run ? (work_ff - TIME_WIDTH'(1)) : work_ff;
      tnp_dec = (tnp_ff != '0) ? (tnp_ff - TIME_WIDTH'(1)) : tnp_ff;
      ttd_next = calc_ttd(tnp_dec, period_ff, deadline_ff);
      if (ctrl.load && load_sel) begin
         work_in = '0;
         tnp_in = '0;
      end
      // Release a job when asked and the period is over
      if (ctrl.release_en && release_bit && tnp_ff == '0) begin
         work_in = wcet_ff;
         tnp_in = period_ff;
      end
      // Load own key into the ring, clear rank count
      if (ctrl.rank_clear) begin
         ahead_in = '0;
         ract_in = my_act;
         rkey_in = my_key;
         ridx_in = RW'(MY_INDEX);
      end
      if (ctrl.rank_step && other_ahead) begin
         ahead_in = ahead_ff + RW'(1);
      end
      // Run, count down, check deadline
      if (ctrl.update) begin
         work_in = work_dec;
         tnp_in = tnp_dec;
         run_in = do_run;
         miss_in = (ttd_next == '0) && (work_dec != '0);
      end else if (ctrl.load) begin
         run_in = 1'b0;
         miss_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcet_ff <= '0;
         period_ff <= '0;
         deadline_ff <= '0;
         work_ff <= '0;
         tnp_ff <= '0;
         ahead_ff <= '0;
         run_ff <= 1'b0;
         miss_ff <= 1'b0;
      end else begin
         if (ctrl.load && load_sel) begin
            wcet_ff <= wcet_value;
            period_ff <= period_value;
            deadline_ff <= deadline_value;
         end
         work_ff <= work_in;
         tnp_ff <= tnp_in;
         ahead_ff <= ahead_in;
         run_ff <= run_in;
         miss_ff <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      ract_ff <= ract_in;
      rkey_ff <= rkey_in;
      ridx_ff <= ridx_in;
   end

   assign ring_act_out = ract_ff;
   assign ring_key_out = rkey_ff;
   assign ring_idx_out = ridx_ff;
   assign active = my_act;
   assign run = run_ff;
   assign missed = miss_ff;

endmodule

/* design/global_multiprocessor_scheduler_tick.sv */
// Global multiprocessor scheduler tick (EDF, fixed priority, least laxity).
// A load request writes the task cell and goes straight to the result state;
// a tick request passes through a release state, a seed state that loads the
// ring, ring shifts in which each task cell compares its key to the key passing
// by and counts those ranking ahead, a run/countdown state and a result state.
// One request is worked at a time; the result waits in an output register and
// the next request is taken once the result has entered that register.
// Depends on gmst_pkg and gmst_cell.
module global_multiprocessor_scheduler_tick #(
   parameter int TASKS = 8,
   parameter int TIME_WIDTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [gmst_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [gmst_pkg::CsrDataWidth-1:0]  csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [gmst_pkg::IndexWidth-1:0] req_task_index,
   input  logic [TIME_WIDTH-1:0]           req_wcet,
   input  logic [TIME_WIDTH-1:0]           req_period,
   input  logic [TIME_WIDTH-1:0]           req_rel_deadline,
   input  logic [gmst_pkg::MaskWidth-1:0]  req_release_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_deadline_miss,
   output logic [gmst_pkg::MaskWidth-1:0]  rsp_missed_tasks,
   output logic [gmst_pkg::MaskWidth-1:0]  rsp_run_tasks,
   output logic [gmst_pkg::MaskWidth-1:0]  rsp_active_tasks
);

   localparam int RW = $clog2(TASKS+1);
   localparam int KW = TIME_WIDTH + 2;
   localparam int CW = $clog2(TASKS+1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RELEASE = 3'd1;
   localparam logic [2:0] ST_SEED = 3'd2;
   localparam logic [2:0] ST_RANK = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_REPORT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [gmst_pkg::ProcWidth-1:0] procs_ff;
   logic [1:0] policy_ff;
   logic opcode_ff;
   logic [gmst_pkg::MaskWidth-1:0] relmask_ff;
   logic out_valid_ff, out_valid_in;
   logic out_miss_ff;
   logic [gmst_pkg::MaskWidth-1:0] out_missed_ff, out_run_ff, out_active_ff;
   logic [RW-1:0] proc_limit;
   logic accept, out_free;
   gmst_pkg::cell_ctrl_type ctrl;

   logic [TASKS-1:0] act_vec, run_vec, miss_vec;
   logic [TASKS-1:0] ring_act;
   logic signed [KW-1:0] ring_key [TASKS];
   logic [RW-1:0] ring_idx [TASKS];
   logic [gmst_pkg::MaskWidth-1:0] act_m, run_m, miss_m;

   // Clamp processor count to the task count
   assign proc_limit = ({28'd0, procs_ff} > 32'(TASKS)) ? RW'(TASKS) : RW'(procs_ff);

   assign out_free = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         procs_ff <= gmst_pkg::ProcWidth'(1);
         policy_ff <= gmst_pkg::POLICY_EDF;
      end else if (csr_write) begin
         case (csr_index)
            gmst_pkg::CSR_PROCESSORS: procs_ff <= csr_data[gmst_pkg::ProcWidth-1:0];
            gmst_pkg::CSR_POLICY: policy_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ctrl = '0;
      ctrl.policy = policy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == gmst_pkg::OP_LOAD) begin
                  ctrl.load = 1'b1;
                  state_in = ST_REPORT;
               end else begin
                  state_in = ST_RELEASE;
               end
            end
         end
         ST_RELEASE: begin
            ctrl.release_en = 1'b1;
            state_in = ST_SEED;
         end
         ST_SEED: begin
            ctrl.rank_clear = 1'b1;
            count_in = '0;
            state_in = (TASKS > 1) ? ST_RANK : ST_UPDATE;
         end
         ST_RANK: begin
            ctrl.rank_step = 1'b1;
            count_in = count_ff + CW'(1);
            if (count_ff == CW'(TASKS-2)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ctrl.update = 1'b1;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= req_opcode;
         relmask_ff <= req_release_mask;
      end
   end

   // Cell chain
   genvar g;
   generate
      for (g = 0; g < TASKS; g++) begin : g_cell
         localparam int PREV = (g == 0) ? TASKS - 1 : g - 1;
         logic rel_bit;
         assign rel_bit = (g < gmst_pkg::MaskWidth) ? relmask_ff[g % gmst_pkg::MaskWidth] : 1'b0;
         gmst_cell #(
            .TIME_WIDTH(TIME_WIDTH),
            .TASKS(TASKS),
            .MY_INDEX(g)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .ctrl(ctrl),
            .load_sel({{(32-gmst_pkg::IndexWidth){1'b0}}, req_task_index} == 32'(g)),
            .release_bit(rel_bit),
            .wcet_value(req_wcet),
            .period_value(req_period),
            .deadline_value(req_rel_deadline),
            .proc_limit(proc_limit),
            .ring_act_in(ring_act[PREV]),
            .ring_key_in(ring_key[PREV]),
            .ring_idx_in(ring_idx[PREV]),
            .ring_act_out(ring_act[g]),
            .ring_key_out(ring_key[g]),
            .ring_idx_out(ring_idx[g]),
            .active(act_vec[g]),
            .run(run_vec[g]),
            .missed(miss_vec[g])
         );
      end
   endgenerate

   // Fold task bits into 8-bit result masks
   always_comb begin
      act_m = '0;
      run_m = '0;
      miss_m = '0;
      for (int k = 0; k < TASKS; k++) begin
         if (k < gmst_pkg::MaskWidth) begin
            act_m[k % gmst_pkg::MaskWidth] = act_vec[k];
            run_m[k % gmst_pkg::MaskWidth] = run_vec[k];
            miss_m[k % gmst_pkg::MaskWidth] = miss_vec[k];
         end
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (state_ff == ST_REPORT && out_free) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_REPORT && out_free) begin
         out_active_ff <= act_m;
         if (opcode_ff == gmst_pkg::OP_TICK) begin
            out_run_ff <= run_m;
            out_missed_ff <= miss_m;
            out_miss_ff <= (miss_m != '0);
         end else begin
            out_run_ff <= '0;
            out_missed_ff <= '0;
            out_miss_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_deadline_miss = out_miss_ff;
   assign rsp_missed_tasks = out_missed_ff;
   assign rsp_run_tasks = out_run_ff;
   assign rsp_active_tasks = out_active_ff;

endmodule

/* bench/tb_global_multiprocessor_scheduler_tick.sv */
// Testbench for the global multiprocessor scheduler tick block.
// Drives load and tick requests, predicts each response and compares it.
// Depends on gmst_pkg and global_multiprocessor_scheduler_tick.
module tb_global_multiprocessor_scheduler_tick;

   localparam int NumTasks = 8;

   typedef struct packed {
      logic       miss;
      logic [7:0] missed;
      logic [7:0] run;
      logic [7:0] active;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [gmst_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [gmst_pkg::CsrDataWidth-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = gmst_pkg::OP_LOAD;
   logic [gmst_pkg::IndexWidth-1:0] req_task_index = '0;
   logic [7:0] req_wcet = '0;
   logic [7:0] req_period = '0;
   logic [7:0] req_rel_deadline = '0;
   logic [gmst_pkg::MaskWidth-1:0] req_release_mask = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_deadline_miss;
   logic [gmst_pkg::MaskWidth-1:0] rsp_missed_tasks;
   logic [gmst_pkg::MaskWidth-1:0] rsp_run_tasks;
   logic [gmst_pkg::MaskWidth-1:0] rsp_active_tasks;

   // Shadow scheduler state
   logic [7:0] work_left [NumTasks];
   logic [7:0] period_left [NumTasks];
   logic [7:0] wcet_tab [NumTasks];
   logic [7:0] period_tab [NumTasks];
   logic [7:0] dline_tab [NumTasks];
   logic [3:0] cpu_count;
   logic [1:0] rank_policy;

   sched_result_type pending_results[$];
   int failures = 0;
   bit idle_en = 1'b1;

   global_multiprocessor_scheduler_tick i_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_task_index(req_task_index), .req_wcet(req_wcet), .req_period(req_period),
      .req_rel_deadline(req_rel_deadline), .req_release_mask(req_release_mask),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_deadline_miss(rsp_deadline_miss), .rsp_missed_tasks(rsp_missed_tasks),
      .rsp_run_tasks(rsp_run_tasks), .rsp_active_tasks(rsp_active_tasks)
   );

   always #5 clock = ~clock;

   function automatic int slack_to_deadline(int t);
      int v;
      v = int'(period_left[t]) - (int'(period_tab[t]) - int'(dline_tab[t]));
      return (v > 0) ? v : 0;
   endfunction

   function automatic bit ahead_of(int a, int b);
      bit wa, wb;
      int ka, kb;
      wa = work_left[a] != 0;
      wb = work_left[b] != 0;
      if (!wa && !wb) return a < b;
      if (wa != wb) return wa;
      if (rank_policy == gmst_pkg::POLICY_FIXED) return a < b;
      ka = slack_to_deadline(a);
      kb = slack_to_deadline(b);
      if (rank_policy == gmst_pkg::POLICY_LLF) begin
         ka -= int'(work_left[a]);
         kb -= int'(work_left[b]);
      end
      if (ka == kb) return a < b;
      return ka < kb;
   endfunction

   function automatic logic [7:0] active_now();
      logic [7:0] m;
      m = '0;
      for (int t = 0; t < NumTasks; t++) m[t] = work_left[t] != 0;
      return m;
   endfunction

   // Advance the shadow state by one request and queue its response
   function automatic void schedule_request(logic op, logic [2:0] idx, logic [7:0] w,
                                            logic [7:0] p, logic [7:0] d, logic [7:0] rel);
      sched_result_type r;
      int cpus, ahead;
      r = '0;
      if (op == gmst_pkg::OP_LOAD) begin
         wcet_tab[idx] = w;
         period_tab[idx] = p;
         dline_tab[idx] = d;
         work_left[idx] = '0;
         period_left[idx] = '0;
      end else begin
         for (int t = 0; t < NumTasks; t++)
            if (rel[t] && period_left[t] == 0) begin
               work_left[t] = wcet_tab[t];
               period_left[t] = period_tab[t];
            end
         cpus = (cpu_count > NumTasks) ? NumTasks : cpu_count;
         for (int t = 0; t < NumTasks; t++) begin
            ahead = 0;
            for (int o = 0; o < NumTasks; o++)
               if (o != t && ahead_of(o, t)) ahead++;
            r.run[t] = (ahead < cpus) && work_left[t] != 0;
         end
         for (int t = 0; t < NumTasks; t++) begin
            if (r.run[t]) work_left[t]--;
            if (period_left[t] != 0) period_left[t]--;
            r.missed[t] = slack_to_deadline(t) == 0 && work_left[t] != 0;
         end
         r.miss = r.missed != 0;
      end
      r.active = active_now();
      pending_results.push_back(r);
   endfunction

   // Send one request, holding it until accepted
   task automatic send_request(logic op, logic [2:0] idx, logic [7:0] w, logic [7:0] p,
                               logic [7:0] d, logic [7:0] rel);
      do @(negedge clock); while (idle_en && $urandom_range(99) < 30);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_index <= idx;
      req_wcet <= w;
      req_period <= p;
      req_rel_deadline <= d;
      req_release_mask <= rel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      schedule_request(op, idx, w, p, d, rel);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_tick(logic [7:0] rel);
      send_request(gmst_pkg::OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), rel);
   endtask

   task automatic send_load(logic [2:0] idx, logic [7:0] w, logic [7:0] p, logic [7:0] d);
      send_request(gmst_pkg::OP_LOAD, idx, w, p, d, 8'($urandom));
   endtask

   // Wait for all responses, then let the block settle before a register write
   task automatic drain_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_register(logic [gmst_pkg::CsrIndexWidth-1:0] idx, logic [3:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == gmst_pkg::CSR_PROCESSORS) cpu_count = val;
      else rank_policy = val[1:0];
      @(negedge clock);
   endtask

   task automatic set_config(logic [3:0] cpus, logic [1:0] pol);
      drain_results();
      write_register(gmst_pkg::CSR_PROCESSORS, cpus);
      write_register(gmst_pkg::CSR_POLICY, {2'b00, pol});
   endtask

   // Directed: field extremes, both opcodes, edge cases
   task automatic test_directed();
      send_load(0, 8'd3, 8'd5, 8'd4);
      send_load(1, 8'd255, 8'd255, 8'd255);
      send_load(2, 8'd0, 8'd0, 8'd0);
      send_load(3, 8'd2, 8'd1, 8'd0);
      send_load(4, 8'd4, 8'd3, 8'd10);
      send_load(7, 8'd1, 8'd2, 8'd2);
      send_tick(8'hFF);
      send_tick(8'h00);
      send_tick(8'hAA);
      send_tick(8'h55);
      send_tick(8'hFF);
      send_load(1, 8'd0, 8'd0, 8'd0);
      send_tick(8'hFF);
      send_tick(8'hFF);
   endtask

   // Random: mostly short periods and ticks so tasks overlap and miss
   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 15)
            send_load(3'($urandom),
                      8'($urandom_range(99) < 80 ? $urandom_range(6) : $urandom),
                      8'($urandom_range(99) < 80 ? $urandom_range(10) : $urandom),
                      8'($urandom_range(99) < 80 ? $urandom_range(10) : $urandom));
         else
            send_tick($urandom_range(99) < 60 ? 8'hFF : 8'($urandom));
      end
   endtask

   // Check each response against the oldest prediction
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_deadline_miss !== want.miss) begin
               $error("deadline_miss exp %0h got %0h", want.miss, rsp_deadline_miss);
               failures++;
            end
            if (rsp_missed_tasks !== want.missed) begin
               $error("missed_tasks exp %0h got %0h", want.missed, rsp_missed_tasks);
               failures++;
            end
            if (rsp_run_tasks !== want.run) begin
               $error("run_tasks exp %0h got %0h", want.run, rsp_run_tasks);
               failures++;
            end
            if (rsp_active_tasks !== want.active) begin
               $error("active_tasks exp %0h got %0h", want.active, rsp_active_tasks);
               failures++;
            end
         end
      end
   end

   // Randomly stall the response side
   always @(negedge clock) rsp_stall <= idle_en && ($urandom_range(99) < 30);

   initial begin
      for (int t = 0; t < NumTasks; t++) begin
         work_left[t] = '0; period_left[t] = '0;
         wcet_tab[t] = '0; period_tab[t] = '0; dline_tab[t] = '0;
      end
      cpu_count = 4'd1;
      rank_policy = gmst_pkg::POLICY_EDF;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      set_config(4'd2, gmst_pkg::POLICY_LLF);
      test_directed();
      set_config(4'd8, gmst_pkg::POLICY_FIXED);
      test_random(80);
      set_config(4'd0, gmst_pkg::POLICY_EDF);
      test_random(30);
      set_config(4'd15, 2'd3);
      test_random(60);
      set_config(4'd3, gmst_pkg::POLICY_LLF);
      idle_en = 1'b0;
      test_random(80);
      idle_en = 1'b1;
      drain_results();
      set_config(4'd1, gmst_pkg::POLICY_EDF);
      test_random(100);
      set_config(4'd4, gmst_pkg::POLICY_FIXED);
      test_random(100);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
